### sv/pprd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic step functions for the pinhole
// primary ray direction core. No dependencies.
package pprd_pkg;

    localparam int PIX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int FOCAL_W    = 20;
    localparam int VEC_W      = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;
    localparam int QMAG_W     = 21;
    localparam int NORM_W     = 30;
    localparam int SQ_W       = 60;
    localparam int RAD_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int SREM_W     = 33;
    localparam int QUO_W      = 31;
    localparam int UNIT_W     = 32;
    localparam int PROD_W     = 64;
    localparam int DIR_W      = 16;
    localparam int RND_SHIFT  = 45;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD = 3'd0,
        CFG_UP      = 3'd1,
        CFG_WIDTH   = 3'd2,
        CFG_HEIGHT  = 3'd3,
        CFG_FOCAL   = 3'd4
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] FORWARD_RST = 63'd8192000;
    localparam logic [CFG_DATA_W-1:0] UP_RST      = 63'd34359738368;
    localparam logic [DIM_W-1:0]      WIDTH_RST   = 13'd640;
    localparam logic [DIM_W-1:0]      HEIGHT_RST  = 13'd480;
    localparam logic [FOCAL_W-1:0]    FOCAL_RST   = 20'd12361;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_acc;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic              qbit;
    } t_div_res;

    typedef struct packed {
        logic                         busy;
        logic                         ok;
        logic [2:0][UNIT_W-1:0]       cx;
        logic [2:0][UNIT_W-1:0]       cy;
        logic [2:0][UNIT_W-1:0]       cz;
    } t_basis;

    typedef struct packed {
        logic                   vld;
        logic                   deg;
        logic [2:0][UNIT_W-1:0] qn;
    } t_ray;

    // One digit of the restoring square root: two radicand bits in, one root bit out.
    function automatic t_sqrt_acc sqrt_step(input t_sqrt_acc acc, input logic [1:0] pair);
        logic [SREM_W+1:0] sh;
        logic [SREM_W+1:0] trial;
        logic [SREM_W+1:0] diff;
        t_sqrt_acc         res;
        sh    = {acc.rem, pair};
        trial = {2'b00, acc.root, 2'b01};
        diff  = sh - trial;
        if (sh >= trial) begin
            res.rem  = diff[SREM_W-1:0];
            res.root = {acc.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = sh[SREM_W-1:0];
            res.root = {acc.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // One bit of restoring division; the remainder stays below the divisor.
    function automatic t_div_res div_step(input logic [ROOT_W-1:0] rem, input logic b,
                                          input logic [ROOT_W-1:0] n);
        logic [ROOT_W:0] t;
        logic [ROOT_W:0] diff;
        t_div_res        res;
        t    = {rem, b};
        diff = t - {1'b0, n};
        if (t >= {1'b0, n}) begin
            res.rem  = diff[ROOT_W-1:0];
            res.qbit = 1'b1;
        end else begin
            res.rem  = t[ROOT_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [PROD_W-1:0] mul_s32(input logic [UNIT_W-1:0] a,
                                                 input logic [UNIT_W-1:0] b);
        logic signed [PROD_W-1:0] ea;
        logic signed [PROD_W-1:0] eb;
        ea = $signed({{(PROD_W-UNIT_W){a[UNIT_W-1]}}, a});
        eb = $signed({{(PROD_W-UNIT_W){b[UNIT_W-1]}}, b});
        return ea * eb;
    endfunction

    function automatic logic [SQ_W-1:0] sq30(input logic [NORM_W-1:0] m);
        logic [SQ_W-1:0] e;
        e = {{(SQ_W-NORM_W){1'b0}}, m};
        return e * e;
    endfunction

    function automatic logic [UNIT_W-1:0] to_unit(input logic neg, input logic [QUO_W-1:0] q);
        logic [UNIT_W-1:0] e;
        e = {1'b0, q};
        return neg ? (~e + 1'b1) : e;
    endfunction

    function automatic logic [UNIT_W-1:0] sext21(input logic [VEC_W-1:0] v);
        return {{(UNIT_W-VEC_W){v[VEC_W-1]}}, v};
    endfunction

endpackage

### sv/pinhole_primary_ray_direction_core.sv
`timescale 1ns / 1ps
// Pinhole camera primary ray direction: configuration registers, ray vector
// setup and stall control. Uses pprd_pkg, pprd_basis, pprd_unit_pipe, pprd_rotate.
//
// Usage:
//   Pixel words enter on i_valid / o_stall with i_pixel_x and i_pixel_y; a word
//   is taken on a clock edge with i_valid high and o_stall low. Result words
//   leave on o_valid / i_stall; a word is taken with o_valid high and i_stall low.
//   One pixel is accepted per clock while o_stall is low; results leave in
//   order, one result per pixel.
//   Registers are written through i_cfg_valid / o_cfg_ready, index and data;
//   o_cfg_ready is always high. Write them only while no pixel is in flight.
//   After reset, and after every write of the forward or up vector, the camera
//   basis is rebuilt by a sequencer sharing one square root and a three-lane divider;
//   o_stall stays high while it runs.
//   When the receiver stalls while o_valid is high, the whole pipeline holds
//   in place and o_stall rises in the same cycle; no word is lost or repeated.
module pinhole_primary_ray_direction_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [pprd_pkg::PIX_W-1:0]             i_pixel_x,
    input  logic [pprd_pkg::PIX_W-1:0]             i_pixel_y,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [pprd_pkg::DIR_W-1:0]      o_dir_x,
    output logic signed [pprd_pkg::DIR_W-1:0]      o_dir_y,
    output logic signed [pprd_pkg::DIR_W-1:0]      o_dir_z,
    output logic                                   o_degenerate,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pprd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pprd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import pprd_pkg::*;

    logic [CFG_DATA_W-1:0]   r_forward;
    logic [CFG_DATA_W-1:0]   r_up;
    logic [DIM_W-1:0]        r_width;
    logic [DIM_W-1:0]        r_height;
    logic [FOCAL_W-1:0]      r_focal;

    logic                    cfg_wr;
    logic                    basis_restart;
    t_basis                  basis;
    t_ray                    ray;
    logic                    pipe_en;
    logic [2:0][DIR_W-1:0]   dir;
    logic [DIM_W-1:0]        w_clamp;
    logic [DIM_W-1:0]        h_clamp;
    logic signed [15:0]      dx;
    logic signed [15:0]      dy;
    logic [15:0]             abs_dx;
    logic [15:0]             abs_dy;
    logic [2:0][QMAG_W-1:0]  q_mag;
    logic [2:0]              q_neg;

    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign basis_restart = cfg_wr && (i_cfg_index == CFG_FORWARD || i_cfg_index == CFG_UP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward <= FORWARD_RST;
            r_up      <= UP_RST;
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
            r_focal   <= FOCAL_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_FORWARD: r_forward <= i_cfg_data;
                CFG_UP:      r_up      <= i_cfg_data;
                CFG_WIDTH:   r_width   <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:  r_height  <= i_cfg_data[DIM_W-1:0];
                CFG_FOCAL:   r_focal   <= i_cfg_data[FOCAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves whenever the output word is empty or being taken.
    assign pipe_en = !(o_valid && i_stall);
    assign o_stall = !pipe_en || basis.busy;

    // Camera-space vector in half-pixel Q16.4 units: doubled offset from center.
    assign w_clamp = ({19'd0, r_width} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_width;
    assign h_clamp = ({19'd0, r_height} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_height;
    assign dx = $signed({3'b000, i_pixel_x, 1'b0}) - $signed({3'b000, w_clamp}) + 16'sd1;
    assign dy = $signed({3'b000, h_clamp}) - 16'sd1 - $signed({3'b000, i_pixel_y, 1'b0});
    assign abs_dx = dx[15] ? 16'(-dx) : 16'(dx);
    assign abs_dy = dy[15] ? 16'(-dy) : 16'(dy);
    assign q_mag[0] = {1'b0, abs_dx, 4'd0};
    assign q_mag[1] = {1'b0, abs_dy, 4'd0};
    assign q_mag[2] = {r_focal, 1'b0};
    assign q_neg    = {1'b0, dy[15], dx[15]};

    pprd_basis u_basis (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (basis_restart),
        .i_forward (r_forward),
        .i_up      (r_up),
        .o_basis   (basis)
    );

    pprd_unit_pipe u_unit_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (i_valid && !o_stall),
        .i_mag   (q_mag),
        .i_neg   (q_neg),
        .o_ray   (ray)
    );

    pprd_rotate u_rotate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (pipe_en),
        .i_ray        (ray),
        .i_basis      (basis),
        .o_valid      (o_valid),
        .o_dir        (dir),
        .o_degenerate (o_degenerate)
    );

    assign o_dir_x = $signed(dir[0]);
    assign o_dir_y = $signed(dir[1]);
    assign o_dir_z = $signed(dir[2]);

endmodule

### sv/pprd_basis.sv
`timescale 1ns / 1ps
// Camera basis sequencer: builds unit forward, right and up vectors from the
// configured vectors with one shared square root and three-lane divider. Uses pprd_pkg.
module pprd_basis (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_restart,
    input  logic [pprd_pkg::CFG_DATA_W-1:0]   i_forward,
    input  logic [pprd_pkg::CFG_DATA_W-1:0]   i_up,
    output pprd_pkg::t_basis                  o_basis
);
    import pprd_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_ABS, S_NORM, S_SQ, S_SUM, S_SQRT, S_DIVINIT, S_DIV,
        S_STORE, S_MUL, S_SUB, S_DONE
    } t_state;

    t_state                     r_state;
    logic [1:0]                 r_phase;
    logic [4:0]                 r_cnt;
    logic                       r_ok;
    logic [2:0][63:0]           r_vec;
    logic [2:0][62:0]           r_mag;
    logic [2:0]                 r_neg;
    logic [62:0]                r_mx;
    logic [2:0][SQ_W-1:0]       r_sq;
    logic [RAD_W-1:0]           r_rad;
    t_sqrt_acc                  r_acc;
    logic [2:0][ROOT_W-1:0]     r_drem;
    logic [2:0][ROOT_W-1:0]     r_lo;
    logic [2:0][QUO_W-1:0]      r_quo;
    logic [5:0][PROD_W-1:0]     r_prod;
    logic [2:0][UNIT_W-1:0]     r_cx;
    logic [2:0][UNIT_W-1:0]     r_cy;
    logic [2:0][UNIT_W-1:0]     r_cz;

    logic [2:0][62:0]           c_abs;
    logic [62:0]                c_mx;
    logic [2:0][UNIT_W-1:0]     c_a;
    logic [2:0][UNIT_W-1:0]     c_b;
    logic [2:0][UNIT_W-1:0]     c_unit;
    logic [2:0][60:0]           c_num;
    t_div_res                   c_div [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_abs[i]  = r_vec[i][63] ? 63'(~r_vec[i] + 64'd1) : r_vec[i][62:0];
            c_unit[i] = to_unit(r_neg[i], r_quo[i]);
            c_num[i]  = {1'b0, r_mag[i][NORM_W-1:0], 30'd0} + 61'(r_acc.root >> 1);
            c_div[i]  = div_step(r_drem[i], r_lo[i][ROOT_W-1], r_acc.root);
        end
        c_mx = c_abs[0];
        if (c_abs[1] > c_mx) begin
            c_mx = c_abs[1];
        end
        if (c_abs[2] > c_mx) begin
            c_mx = c_abs[2];
        end
        // Second phase crosses up with forward, third crosses forward with right.
        if (r_phase == 2'd1) begin
            for (int i = 0; i < 3; i++) begin
                c_a[i] = sext21(i_up[VEC_W*i +: VEC_W]);
                c_b[i] = r_cz[i];
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                c_a[i] = r_cz[i];
                c_b[i] = r_cx[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= S_LOAD;
            r_phase <= 2'd0;
            r_ok    <= 1'b1;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    r_ok <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        r_vec[i] <= {{(64-VEC_W){i_forward[VEC_W*i+VEC_W-1]}},
                                     i_forward[VEC_W*i +: VEC_W]};
                    end
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= c_abs[i];
                        r_neg[i] <= r_vec[i][63];
                    end
                    r_mx    <= c_mx;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // Scale by one bit a cycle until the largest magnitude is in [2^29, 2^30).
                    if (r_mx == '0) begin
                        r_ok    <= 1'b0;
                        r_quo   <= '0;
                        r_state <= S_STORE;
                    end else if (r_mx[62:30] != '0) begin
                        r_mx <= r_mx >> 1;
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                    end else if (!r_mx[29]) begin
                        r_mx <= r_mx << 1;
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] << 1;
                        end
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_sq[i] <= sq30(r_mag[i][NORM_W-1:0]);
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_rad   <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_acc <= sqrt_step(r_acc, r_rad[RAD_W-1 -: 2]);
                    r_rad <= r_rad << 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SQRT_STEPS - 1)) begin
                        r_state <= S_DIVINIT;
                    end
                end
                S_DIVINIT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_drem[i] <= {1'b0, c_num[i][60:31]};
                        r_lo[i]   <= c_num[i][30:0];
                    end
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        r_drem[i] <= c_div[i].rem;
                        r_quo[i]  <= {r_quo[i][QUO_W-2:0], c_div[i].qbit};
                        r_lo[i]   <= r_lo[i] << 1;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    case (r_phase)
                        2'd0:    r_cz <= c_unit;
                        2'd1:    r_cx <= c_unit;
                        default: r_cy <= c_unit;
                    endcase
                    if (r_phase == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_phase <= r_phase + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod[0] <= mul_s32(c_a[1], c_b[2]);
                    r_prod[1] <= mul_s32(c_a[2], c_b[1]);
                    r_prod[2] <= mul_s32(c_a[2], c_b[0]);
                    r_prod[3] <= mul_s32(c_a[0], c_b[2]);
                    r_prod[4] <= mul_s32(c_a[0], c_b[1]);
                    r_prod[5] <= mul_s32(c_a[1], c_b[0]);
                    r_state   <= S_SUB;
                end
                S_SUB: begin
                    r_vec[0] <= r_prod[0] - r_prod[1];
                    r_vec[1] <= r_prod[2] - r_prod[3];
                    r_vec[2] <= r_prod[4] - r_prod[5];
                    r_state  <= S_ABS;
                end
                S_DONE: begin
                    r_state <= S_DONE;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_basis.busy = (r_state != S_DONE);
    assign o_basis.ok   = r_ok;
    assign o_basis.cx   = r_cx;
    assign o_basis.cy   = r_cy;
    assign o_basis.cz   = r_cz;

endmodule

### sv/pprd_unit_pipe.sv
`timescale 1ns / 1ps
// Pipelined normalization of the camera-space ray vector: scaling, sum of
// squares, one square root digit and one quotient bit per stage. Uses pprd_pkg.
module pprd_unit_pipe (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic [2:0][pprd_pkg::QMAG_W-1:0]     i_mag,
    input  logic [2:0]                           i_neg,
    output pprd_pkg::t_ray                       o_ray
);
    import pprd_pkg::*;

    logic                         r_p0_vld, r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld, r_pp_vld;
    logic [2:0][QMAG_W-1:0]       r_p0_mag, r_p1_mag;
    logic [2:0]                   r_p0_neg, r_p1_neg, r_p2_neg, r_p3_neg, r_p4_neg, r_pp_neg;
    logic [4:0]                   r_p1_len;
    logic                         r_p1_zero, r_p2_zero, r_p3_zero, r_p4_zero, r_pp_zero;
    logic [2:0][NORM_W-1:0]       r_p2_m, r_p3_m, r_p4_m;
    logic [2:0][SQ_W-1:0]         r_p3_sq;
    logic [RAD_W-1:0]             r_p4_rad;
    logic [ROOT_W-1:0]            r_pp_n;
    logic [2:0][ROOT_W-1:0]       r_pp_rem;
    logic [2:0][ROOT_W-1:0]       r_pp_lo;

    logic                         r_sq_vld  [SQRT_STEPS];
    t_sqrt_acc                    r_sq_acc  [SQRT_STEPS];
    logic [RAD_W-1:0]             r_sq_rad  [SQRT_STEPS];
    logic [2:0][NORM_W-1:0]       r_sq_m    [SQRT_STEPS];
    logic [2:0]                   r_sq_neg  [SQRT_STEPS];
    logic                         r_sq_zero [SQRT_STEPS];

    logic                         r_dv_vld  [DIV_STEPS];
    logic [2:0][ROOT_W-1:0]       r_dv_rem  [DIV_STEPS];
    logic [2:0][ROOT_W-1:0]       r_dv_lo   [DIV_STEPS];
    logic [2:0][QUO_W-1:0]        r_dv_quo  [DIV_STEPS];
    logic [ROOT_W-1:0]            r_dv_n    [DIV_STEPS];
    logic [2:0]                   r_dv_neg  [DIV_STEPS];
    logic                         r_dv_zero [DIV_STEPS];

    logic [QMAG_W-1:0]            c_mx;
    logic [4:0]                   c_len;
    logic [4:0]                   c_sh;
    logic [2:0][NORM_W-1:0]       c_m;
    logic [2:0][60:0]             c_num;

    always_comb begin
        c_mx = r_p0_mag[0];
        if (r_p0_mag[1] > c_mx) begin
            c_mx = r_p0_mag[1];
        end
        if (r_p0_mag[2] > c_mx) begin
            c_mx = r_p0_mag[2];
        end
        c_len = '0;
        for (int b = 0; b < QMAG_W; b++) begin
            if (c_mx[b]) begin
                c_len = 5'(b + 1);
            end
        end
        // The largest magnitude lands in [2^29, 2^30); it never needs a right shift here.
        c_sh = 5'(NORM_W) - r_p1_len;
        for (int i = 0; i < 3; i++) begin
            c_m[i]   = NORM_W'({{(NORM_W-QMAG_W){1'b0}}, r_p1_mag[i]} << c_sh);
            c_num[i] = {1'b0, r_sq_m[SQRT_STEPS-1][i], 30'd0}
                     + 61'(r_sq_acc[SQRT_STEPS-1].root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_pp_vld <= 1'b0;
        end else if (i_en) begin
            r_p0_vld <= i_vld;
            r_p1_vld <= r_p0_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
            r_pp_vld <= r_sq_vld[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0_mag  <= i_mag;
            r_p0_neg  <= i_neg;
            r_p1_mag  <= r_p0_mag;
            r_p1_neg  <= r_p0_neg;
            r_p1_len  <= c_len;
            r_p1_zero <= (c_mx == '0);
            r_p2_m    <= c_m;
            r_p2_neg  <= r_p1_neg;
            r_p2_zero <= r_p1_zero;
            for (int i = 0; i < 3; i++) begin
                r_p3_sq[i] <= sq30(r_p2_m[i]);
            end
            r_p3_m    <= r_p2_m;
            r_p3_neg  <= r_p2_neg;
            r_p3_zero <= r_p2_zero;
            r_p4_rad  <= {2'b00, r_p3_sq[0]} + {2'b00, r_p3_sq[1]} + {2'b00, r_p3_sq[2]};
            r_p4_m    <= r_p3_m;
            r_p4_neg  <= r_p3_neg;
            r_p4_zero <= r_p3_zero;
            r_pp_n    <= r_sq_acc[SQRT_STEPS-1].root;
            for (int i = 0; i < 3; i++) begin
                r_pp_rem[i] <= {1'b0, c_num[i][60:31]};
                r_pp_lo[i]  <= c_num[i][30:0];
            end
            r_pp_neg  <= r_sq_neg[SQRT_STEPS-1];
            r_pp_zero <= r_sq_zero[SQRT_STEPS-1];
        end
    end

    // Square root: stage k consumes radicand bits 61-2k and 60-2k.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_sq_vld[k] <= r_p4_vld;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq_acc[k]  <= sqrt_step('0, r_p4_rad[RAD_W-1 -: 2]);
                    r_sq_rad[k]  <= r_p4_rad;
                    r_sq_m[k]    <= r_p4_m;
                    r_sq_neg[k]  <= r_p4_neg;
                    r_sq_zero[k] <= r_p4_zero;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_sq_vld[k] <= r_sq_vld[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq_acc[k]  <= sqrt_step(r_sq_acc[k-1], r_sq_rad[k-1][RAD_W-1-2*k -: 2]);
                    r_sq_rad[k]  <= r_sq_rad[k-1];
                    r_sq_m[k]    <= r_sq_m[k-1];
                    r_sq_neg[k]  <= r_sq_neg[k-1];
                    r_sq_zero[k] <= r_sq_zero[k-1];
                end
            end
        end
    end

    // Division: stage k brings in dividend bit 30-k of all three lanes.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        t_div_res            c_d [3];
        logic [2:0][ROOT_W-1:0] c_rem_in;
        logic [2:0][ROOT_W-1:0] c_lo_in;
        logic [2:0][QUO_W-1:0]  c_quo_in;
        logic [ROOT_W-1:0]      c_n_in;

        if (k == 0) begin : g_src_first
            assign c_rem_in = r_pp_rem;
            assign c_lo_in  = r_pp_lo;
            assign c_quo_in = '0;
            assign c_n_in   = r_pp_n;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_dv_vld[k] <= r_pp_vld;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv_neg[k]  <= r_pp_neg;
                    r_dv_zero[k] <= r_pp_zero;
                end
            end
        end else begin : g_src_rest
            assign c_rem_in = r_dv_rem[k-1];
            assign c_lo_in  = r_dv_lo[k-1];
            assign c_quo_in = r_dv_quo[k-1];
            assign c_n_in   = r_dv_n[k-1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_dv_vld[k] <= r_dv_vld[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv_neg[k]  <= r_dv_neg[k-1];
                    r_dv_zero[k] <= r_dv_zero[k-1];
                end
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                c_d[i] = div_step(c_rem_in[i], c_lo_in[i][ROOT_W-1-k], c_n_in);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[k][i] <= c_d[i].rem;
                    r_dv_quo[k][i] <= {c_quo_in[i][QUO_W-2:0], c_d[i].qbit};
                end
                r_dv_lo[k] <= c_lo_in;
                r_dv_n[k]  <= c_n_in;
            end
        end
    end

    assign o_ray.vld = r_dv_vld[DIV_STEPS-1];
    assign o_ray.deg = r_dv_zero[DIV_STEPS-1];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_ray.qn[i] = to_unit(r_dv_neg[DIV_STEPS-1][i], r_dv_quo[DIV_STEPS-1][i]);
        end
    end

endmodule

### sv/pprd_rotate.sv
`timescale 1ns / 1ps
// Rotation of the unit camera-space ray into the world basis, rounding to
// Q1.15 with saturation, and the output register. Uses pprd_pkg.
module pprd_rotate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  pprd_pkg::t_ray                     i_ray,
    input  pprd_pkg::t_basis                   i_basis,
    output logic                               o_valid,
    output logic [2:0][pprd_pkg::DIR_W-1:0]    o_dir,
    output logic                               o_degenerate
);
    import pprd_pkg::*;

    logic                        r_mul_vld, r_sum_vld, r_out_vld;
    logic                        r_mul_deg, r_sum_deg, r_out_deg;
    logic [2:0][2:0][PROD_W-1:0] r_prod;
    logic [2:0][PROD_W-1:0]      r_sum;
    logic [2:0][DIR_W-1:0]       r_dir;

    logic [2:0][PROD_W-1:0]      c_biased;
    logic signed [PROD_W-RND_SHIFT-1:0] c_rnd [3];
    logic [2:0][DIR_W-1:0]       c_dir;
    logic                        c_deg;

    always_comb begin
        c_deg = r_sum_deg || !i_basis.ok;
        for (int i = 0; i < 3; i++) begin
            // Round half up: add half an LSB, then floor through the arithmetic shift.
            c_biased[i] = r_sum[i] + (64'd1 << (RND_SHIFT - 1));
            c_rnd[i]    = $signed(c_biased[i][PROD_W-1:RND_SHIFT]);
            if (c_deg) begin
                c_dir[i] = '0;
            end else if (c_rnd[i] > 19'sd32767) begin
                c_dir[i] = 16'h7FFF;
            end else if (c_rnd[i] < -19'sd32768) begin
                c_dir[i] = 16'h8000;
            end else begin
                c_dir[i] = c_rnd[i][DIR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
            r_sum_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_mul_vld <= i_ray.vld;
            r_sum_vld <= r_mul_vld;
            r_out_vld <= r_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i][0] <= mul_s32(i_ray.qn[0], i_basis.cx[i]);
                r_prod[i][1] <= mul_s32(i_ray.qn[1], i_basis.cy[i]);
                r_prod[i][2] <= mul_s32(i_ray.qn[2], i_basis.cz[i]);
                r_sum[i]     <= r_prod[i][0] + r_prod[i][1] + r_prod[i][2];
            end
            r_mul_deg <= i_ray.deg;
            r_sum_deg <= r_mul_deg;
            r_out_deg <= c_deg;
            r_dir     <= c_dir;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_dir        = r_dir;
    assign o_degenerate = r_out_deg;

endmodule

### tb/tb_pinhole_primary_ray_direction_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for pinhole_primary_ray_direction_core: random and directed
// pixels and camera settings, checked against a fixed-point direction predictor.
// Depends on pprd_pkg and the core RTL.
module tb_pinhole_primary_ray_direction_core;
    import pprd_pkg::*;

    localparam int MAX_DIM   = 4096;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
    } t_pixel;

    typedef struct {
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
        logic                    deg;
    } t_dir;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [PIX_W-1:0]         i_pixel_x = '0;
    logic [PIX_W-1:0]         i_pixel_y = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DIR_W-1:0]  o_dir_x, o_dir_y, o_dir_z;
    logic                     o_degenerate;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    pinhole_primary_ray_direction_core #(.MAX_DIM(MAX_DIM)) dut (.*);

    always #4 i_clk = ~i_clk;

    // Camera settings as the core should hold them.
    logic [CFG_DATA_W-1:0] cam_forward, cam_up;
    logic [DIM_W-1:0]      cam_width, cam_height;
    logic [FOCAL_W-1:0]    cam_focal;

    t_pixel pixel_queue[$];
    t_dir   dir_queue[$];
    bit     word_held = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     errors = 0;
    int     quiet_cycles = 0;

    function automatic longint unsigned root64(input longint unsigned a);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > a) b >>= 2;
        while (b != 0) begin
            if (a >= res + b) begin
                a -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Scales v to a Q2.30 unit vector; returns 0 when v has zero length.
    function automatic bit make_unit(input longint v[3], output longint u[3]);
        longint unsigned m[3], mx, sum, n, q;
        int len;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            u[0] = 0; u[1] = 0; u[2] = 0;
            return 0;
        end
        len = 0;
        while (len < 64 && (mx >> len) != 0) len++;
        for (int i = 0; i < 3; i++) begin
            if (len > 30) m[i] >>= (len - 30);
            else m[i] <<= (30 - len);
            sum += m[i] * m[i];
        end
        n = root64(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (n >> 1)) / n;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic signed [DIR_W-1:0] round_q15(input longint s);
        longint unsigned t;
        longint r;
        t = longint'(s) + (64'd1 << 44) + (64'd1 << 62);
        r = longint'(t >> 45) - (64'sd1 << 17);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[DIR_W-1:0];
    endfunction

    function automatic t_dir ray_direction(input t_pixel p);
        longint fw[3], up[3], bz[3], bx[3], by[3], t[3], q[3], qn[3], w, h;
        logic [VEC_W-1:0] c;
        bit ok;
        t_dir d;
        for (int i = 0; i < 3; i++) begin
            c = cam_forward[21*i +: 21];
            fw[i] = longint'($signed(c));
            c = cam_up[21*i +: 21];
            up[i] = longint'($signed(c));
        end
        ok = make_unit(fw, bz);
        cross3(up, bz, t);
        ok &= make_unit(t, bx);
        cross3(bz, bx, t);
        ok &= make_unit(t, by);
        w = cam_width > MAX_DIM ? MAX_DIM : cam_width;
        h = cam_height > MAX_DIM ? MAX_DIM : cam_height;
        q[0] = (2 * longint'(p.x) - (w - 1)) * 16;
        q[1] = ((h - 1) - 2 * longint'(p.y)) * 16;
        q[2] = 2 * longint'(cam_focal);
        ok &= make_unit(q, qn);
        d.dx = ok ? round_q15(qn[0] * bx[0] + qn[1] * by[0] + qn[2] * bz[0]) : '0;
        d.dy = ok ? round_q15(qn[0] * bx[1] + qn[1] * by[1] + qn[2] * bz[1]) : '0;
        d.dz = ok ? round_q15(qn[0] * bx[2] + qn[1] * by[2] + qn[2] * bz[2]) : '0;
        d.deg = !ok;
        return d;
    endfunction

    // Pixel driver: a word stays on the port until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && !word_held) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_pixel_x <= pixel_queue[0].x;
                i_pixel_y <= pixel_queue[0].y;
                void'(pixel_queue.pop_front());
                i_valid <= 1'b1;
                word_held = 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= $urandom_range(99) < stall_pct;
    end

    // Acceptance, prediction and result checking.
    always @(posedge i_clk) begin
        t_pixel p;
        t_dir   e;
        bit     moved;
        moved = 0;
        if (i_rst_n && i_valid && !o_stall) begin
            p.x = i_pixel_x;
            p.y = i_pixel_y;
            dir_queue.push_back(ray_direction(p));
            word_held = 0;
            moved = 1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            moved = 1;
            if (dir_queue.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = dir_queue.pop_front();
                if (o_dir_x !== e.dx) begin
                    $error("dir_x expected %0d actual %0d", e.dx, o_dir_x); errors++;
                end
                if (o_dir_y !== e.dy) begin
                    $error("dir_y expected %0d actual %0d", e.dy, o_dir_y); errors++;
                end
                if (o_dir_z !== e.dz) begin
                    $error("dir_z expected %0d actual %0d", e.dz, o_dir_z); errors++;
                end
                if (o_degenerate !== e.deg) begin
                    $error("degenerate expected %0d actual %0d", e.deg, o_degenerate);
                    errors++;
                end
            end
        end
        if (moved)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("FAIL pinhole_primary_ray_direction_core");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FORWARD: cam_forward = value;
            CFG_UP:      cam_up = value;
            CFG_WIDTH:   cam_width = value[DIM_W-1:0];
            CFG_HEIGHT:  cam_height = value[DIM_W-1:0];
            CFG_FOCAL:   cam_focal = value[FOCAL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_camera(input logic [CFG_DATA_W-1:0] fw, up,
                              input logic [DIM_W-1:0] w, h, input logic [FOCAL_W-1:0] f);
        write_reg(CFG_FORWARD, fw);
        write_reg(CFG_UP, up);
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_FOCAL, CFG_DATA_W'(f));
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0 || word_held || dir_queue.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic add_pixel(input int x, input int y);
        t_pixel p;
        p.x = PIX_W'(x);
        p.y = PIX_W'(y);
        pixel_queue.push_back(p);
    endtask

    function automatic logic [VEC_W-1:0] rand_comp();
        case ($urandom_range(5))
            0: return 21'h100000;
            1: return 21'h0FFFFF;
            2: return 21'(int'($urandom_range(32)) - 16);
            3: return 21'd0;
            default: return 21'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_vec();
        return {rand_comp(), rand_comp(), rand_comp()};
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(6))
            0: return 13'd1;
            1: return 13'd4096;
            2: return 13'h1FFF;
            3: return 13'd0;
            default: return 13'($urandom_range(1, 8191));
        endcase
    endfunction

    initial begin
        cam_forward = FORWARD_RST;
        cam_up      = UP_RST;
        cam_width   = WIDTH_RST;
        cam_height  = HEIGHT_RST;
        cam_focal   = FOCAL_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset camera: image corners, center, and pixels far outside the image.
        add_pixel(0, 0);
        add_pixel(639, 479);
        add_pixel(320, 240);
        add_pixel(4095, 4095);
        add_pixel(4095, 0);
        add_pixel(0, 4095);
        drain();
        // Zero forward vector.
        set_camera('0, UP_RST, 13'd640, 13'd480, 20'd12361);
        add_pixel(10, 10);
        drain();
        // Up parallel to forward.
        set_camera(FORWARD_RST, FORWARD_RST, 13'd640, 13'd480, 20'd12361);
        add_pixel(100, 200);
        drain();
        // Zero ray: one-pixel image, zero focal distance.
        set_camera({21'd0, 21'h0FFFFF, 21'h100000}, {21'h100000, 21'd0, 21'h0FFFFF},
                   13'd1, 13'd1, 20'd0);
        add_pixel(0, 0);
        add_pixel(1, 0);
        drain();
        // Oversized and zero image sizes, largest focal distance.
        set_camera(rand_vec(), rand_vec(), 13'h1FFF, 13'd0, 20'hFFFFF);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(2048, 2048);
        drain();
        set_camera(FORWARD_RST, UP_RST, 13'd4096, 13'd4096, 20'd1);
        add_pixel(2047, 2048);
        add_pixel(0, 4095);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            set_camera(rand_vec(), rand_vec(), rand_dim(), rand_dim(),
                       $urandom_range(3) == 0 ? 20'($urandom_range(1, 16)) : 20'($urandom));
            for (int k = 0; k < 120; k++) begin
                if ($urandom_range(1))
                    add_pixel($urandom_range(4095), $urandom_range(4095));
                else
                    add_pixel($urandom_range(cam_width > 0 ? cam_width - 1 : 0) % 4096,
                              $urandom_range(cam_height > 0 ? cam_height - 1 : 0) % 4096);
            end
            drain();
        end

        if (errors == 0)
            $display("PASS pinhole_primary_ray_direction_core");
        else
            $display("FAIL pinhole_primary_ray_direction_core");
        $finish;
    end

endmodule

### sim.f
sv/pprd_pkg.sv
sv/pprd_basis.sv
sv/pprd_unit_pipe.sv
sv/pprd_rotate.sv
sv/pinhole_primary_ray_direction_core.sv
tb/tb_pinhole_primary_ray_direction_core.sv
